// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Signal never high while another is high
`define ASSERT_NEVER(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !((a) && (b))) else $error(msg);

`endif

// ----- hdl/loo_pkg.sv -----
// ----------------------------------------------------------------------------
// loo_pkg
// Shared types and constants for the leave-one-out t outlier check.
// ----------------------------------------------------------------------------
package loo_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 24;
    localparam int unsigned CRIT_BITS       = 24;
    localparam int unsigned CRIT_FRAC_BITS  = 16;
    localparam logic [CRIT_BITS-1:0] CRIT_RESET = 24'd409600;
    localparam int unsigned MIN_SAMPLES     = 3;
    // Comparison width: lhs/rhs bounded well below this for the default parameters
    localparam int unsigned WIDE_BITS       = 192;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD,
        ST_FETCH,
        ST_MUL_A,
        ST_WAIT_A,
        ST_MUL_B,
        ST_WAIT_B,
        ST_MUL_C,
        ST_WAIT_C,
        ST_MUL_D,
        ST_WAIT_D,
        ST_CMP,
        ST_OUT
    } loo_state_t;

    typedef enum logic [2:0] {
        MSEL_DD,     // D*D
        MSEL_DDN,    // (D*D)*(n-2)
        MSEL_QM,     // Qo*m
        MSEL_TT,     // To*To
        MSEL_VM,     // (m*Qo-To^2)*m
        MSEL_VC      // (...)*t_crit_sq
    } loo_msel_t;

    // controller -> datapath commands
    typedef struct packed {
        logic      clear;
        logic      latch_x;
        logic      mul_start;
        loo_msel_t msel;
        logic      save_lhs;
        logic      save_qm;
        logic      save_var;
    } loo_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic mul_done;
        logic outlier;
    } loo_sts_t;

endpackage

// ----- hdl/loo_ram.sv -----
// ----------------------------------------------------------------------------
// loo_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module loo_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/loo_ctrl.sv -----
// ----------------------------------------------------------------------------
// loo_ctrl
// Sequencer: load phase, then per-sample test through the serial multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module loo_ctrl #(
    parameter int unsigned CNT_BITS = 11
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic                   in_last,
    input  logic [CNT_BITS-1:0]    count,
    output logic [CNT_BITS-1:0]    rd_idx,
    output logic                   in_ready,
    output logic                   out_valid,
    output logic                   out_passes,
    output logic                   out_too_few,
    input  logic                   out_ready,
    output loo_pkg::loo_cmd_t      cmd,
    input  loo_pkg::loo_sts_t      sts
);
    import loo_pkg::*;

    loo_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic                pass_reg, pass_next;
    logic                few_reg, few_next;

    assign rd_idx      = idx_reg;
    assign in_ready    = (state_reg == ST_LOAD);
    assign out_valid   = (state_reg == ST_OUT);
    assign out_passes  = pass_reg;
    assign out_too_few = few_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            pass_reg  <= 1'b0;
            few_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            few_reg   <= few_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        few_next   = few_reg;
        cmd        = '0;
        cmd.msel   = MSEL_DD;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire && in_last) begin
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    few_next   = 1'b0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                // count now includes the closing item
                if (count < CNT_BITS'(MIN_SAMPLES)) begin
                    pass_next  = 1'b0;
                    few_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.latch_x = 1'b1;
                state_next  = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_start = 1'b1; cmd.msel = MSEL_DD;
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                cmd.msel = MSEL_DD;
                if (sts.mul_done) begin
                    cmd.mul_start = 1'b1; cmd.msel = MSEL_DDN;
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                cmd.msel = MSEL_DDN;
                if (sts.mul_done) begin
                    cmd.save_lhs = 1'b1;
                    cmd.mul_start = 1'b1; cmd.msel = MSEL_QM;
                    state_next = ST_WAIT_B;
                end
            end
            ST_WAIT_B: begin
                cmd.msel = MSEL_QM;
                if (sts.mul_done) begin
                    cmd.save_qm = 1'b1;
                    cmd.mul_start = 1'b1; cmd.msel = MSEL_TT;
                    state_next = ST_MUL_C;
                end
            end
            ST_MUL_C: begin
                cmd.msel = MSEL_TT;
                if (sts.mul_done) begin
                    cmd.save_var = 1'b1;
                    state_next = ST_WAIT_C;
                end
            end
            ST_WAIT_C: begin
                cmd.mul_start = 1'b1; cmd.msel = MSEL_VM;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.msel = MSEL_VM;
                if (sts.mul_done) begin
                    cmd.save_var = 1'b1;
                    state_next = ST_WAIT_D;
                end
            end
            ST_WAIT_D: begin
                cmd.mul_start = 1'b1; cmd.msel = MSEL_VC;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.msel = MSEL_VC;
                if (sts.mul_done) begin
                    state_next = ST_OUT;
                    if (sts.outlier) begin
                        pass_next = 1'b0;
                    end else if (idx_reg != count - 1'b1) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    `ASSERT_NEVER(a_no_in_during_out, aclk, aresetn, in_ready, out_valid, "ready while result shown")
    `ASSERT_CLK(a_few_fails, aclk, aresetn, (out_valid && out_too_few) |-> !out_passes, "too_few with passes")
    `ASSERT_CLK(a_idx_range, aclk, aresetn, (state_reg == ST_FETCH) |-> (idx_reg < count), "index beyond count")
endmodule

// ----- hdl/loo_dp.sv -----
// ----------------------------------------------------------------------------
// loo_dp
// Datapath: sample store, running sums, serial multiplier and comparator.
// ----------------------------------------------------------------------------
module loo_dp #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned CNT_BITS    = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_fire,
    input  logic [SAMPLE_BITS-1:0]            in_delay,
    input  logic [loo_pkg::CRIT_BITS-1:0]     crit,
    input  logic [CNT_BITS-1:0]               rd_idx,
    output logic [CNT_BITS-1:0]               count,
    input  loo_pkg::loo_cmd_t                 cmd,
    output loo_pkg::loo_sts_t                 sts
);
    import loo_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned W  = WIDE_BITS;

    logic [CNT_BITS-1:0]    cnt_reg;
    logic [W-1:0]           sum_reg, sq_reg;
    logic [SAMPLE_BITS-1:0] rdata, x_reg;
    logic [W-1:0]           lhs_reg, qm_reg, var_reg;
    logic [W-1:0]           t_reg, d_reg;
    logic                   full;

    assign count = cnt_reg;
    assign full  = (cnt_reg == CNT_BITS'(MAX_SAMPLES));

    loo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk (aclk),
        .we   (in_fire && !full),
        .waddr(cnt_reg[AW-1:0]),
        .wdata(in_delay),
        .raddr(rd_idx[AW-1:0]),
        .rdata(rdata)
    );

    // running count, sum and square sum over the load phase
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (in_fire && !full) begin
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + W'(in_delay);
            sq_reg  <= sq_reg + W'(W'(in_delay) * W'(in_delay));
        end
    end

    // per-sample terms: To and |n*x - T|, the latter with one multiply
    logic [W-1:0] nx;
    assign nx = W'(cnt_reg) * W'(rdata);
    always_ff @(posedge aclk) begin
        if (cmd.latch_x) begin
            x_reg <= rdata;
            t_reg <= sum_reg - W'(rdata);
            d_reg <= (nx >= sum_reg) ? nx - sum_reg : sum_reg - nx;
        end
    end

    // shift-and-add multiplier: wide a times b, one bit of b per cycle,
    // finishing once no set bit of b is left
    logic [W-1:0]  ma, mb, acc_reg, a_reg, b_reg;
    logic          busy_reg;
    logic [W-1:0]  m_ext, qo;

    assign m_ext = W'(cnt_reg) - W'(1);
    assign qo    = sq_reg - W'(W'(x_reg) * W'(x_reg));

    always_comb begin
        case (cmd.msel)
            MSEL_DD:  begin ma = d_reg;   mb = d_reg; end
            MSEL_DDN: begin ma = acc_reg; mb = W'(cnt_reg) - W'(2); end
            MSEL_QM:  begin ma = qo;      mb = m_ext; end
            MSEL_TT:  begin ma = t_reg;   mb = t_reg; end
            MSEL_VM:  begin ma = var_reg; mb = m_ext; end
            MSEL_VC:  begin ma = var_reg; mb = W'(crit); end
            default:  begin ma = '0;      mb = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.mul_start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && b_reg[W-1:1] == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            acc_reg <= '0;
            a_reg   <= ma;
            b_reg   <= mb;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    // product registers; rhs compare against lhs scaled by 2^16
    always_ff @(posedge aclk) begin
        if (cmd.save_lhs) lhs_reg <= acc_reg << CRIT_FRAC_BITS;
        if (cmd.save_qm)  qm_reg  <= acc_reg;
        if (cmd.save_var) var_reg <= cmd.msel == MSEL_TT ? qm_reg - acc_reg : acc_reg;
    end

    assign sts.mul_done = !busy_reg;
    assign sts.outlier  = lhs_reg > acc_reg;
endmodule

// ----- hdl/loo_t_outlier_check_core.sv -----
// Leave-one-out t outlier check. Samples are taken one item per cycle while
// loading; the item with tlast closes the set and starts the test, during
// which s_tready is low. Each sample costs six passes of the shift-and-add
// multiplier, each taking one bit of its b operand per cycle up to the highest
// set bit (at least one), plus store read and sequencing states. The test
// stops at the first outlier. With fewer than three samples the controller
// goes from its read state straight to the result, with too_few set. Up to
// MAX_SAMPLES samples are kept, later ones dropped.
// ----------------------------------------------------------------------------
// loo_t_outlier_check_core
// Top level: stream ports, APB register, controller and datapath.
// ----------------------------------------------------------------------------
module loo_t_outlier_check_core #(
    parameter int unsigned MAX_SAMPLES = loo_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned SAMPLE_BITS = loo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // delay
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata, // passes, too_few
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import loo_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(MAX_SAMPLES + 1);

    logic [CRIT_BITS-1:0] crit_reg;
    logic [CNT_BITS-1:0]  count, rd_idx;
    logic                 passes, too_few, in_fire;
    loo_cmd_t             cmd;
    loo_sts_t             sts;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_reg <= CRIT_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            crit_reg <= pwdata[CRIT_BITS-1:0];
        end
    end
    assign prdata = (paddr == 2'd0) ? 32'(crit_reg) : '0;

    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = {6'd0, too_few, passes};

    loo_ctrl #(.CNT_BITS(CNT_BITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .count(count), .rd_idx(rd_idx), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_passes(passes), .out_too_few(too_few),
        .out_ready(m_tready), .cmd(cmd), .sts(sts)
    );

    loo_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS), .CNT_BITS(CNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_delay(s_tdata[SAMPLE_BITS-1:0]), .crit(crit_reg), .rd_idx(rd_idx),
        .count(count), .cmd(cmd), .sts(sts)
    );
endmodule
